FILE: src/bresenham_line_pixel_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line pixel generator
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define BLPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BLPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/blpg_pkg.sv
// ----------------------------------------------------------------------------
// blpg_pkg
// Shared types and constants of the line pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package blpg_pkg;

    localparam int FIELD_W      = 16;
    localparam int RGB_W        = 24;
    localparam int RGB565_W     = 16;
    localparam int BRIGHT_W     = 8;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'hff;
    localparam logic [BRIGHT_W-1:0] BRIGHT_BLACK = 8'h00;
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 8'hff;

    localparam logic [RGB_W-1:0]    RGB_R_MASK  = 24'hf80000;
    localparam logic [RGB_W-1:0]    RGB_G_MASK  = 24'h00fc00;
    localparam logic [RGB_W-1:0]    RGB_B_MASK  = 24'h0000f8;
    localparam logic [RGB565_W-1:0] RGB565_R    = 16'b1111100000000000;
    localparam logic [RGB565_W-1:0] RGB565_G    = 16'b0000011111100000;
    localparam logic [RGB565_W-1:0] RGB565_B    = 16'b0000000000011111;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pixel_x;
        logic signed [FIELD_W-1:0] pixel_y;
        logic [RGB565_W-1:0]       pixel_color;
        logic                      last_pixel;
    } t_pixel;

    // top -> engine
    typedef struct packed {
        logic fire;
        logic start;
    } t_eng_ctl;

    // engine -> top
    typedef struct packed {
        logic line_active;
    } t_eng_sts;

endpackage

`default_nettype wire

FILE: src/blpg_if.sv
// ----------------------------------------------------------------------------
// blpg_req_if / blpg_pix_if
// Valid/ready channels for request words and pixel words.
// ----------------------------------------------------------------------------
`default_nettype none

interface blpg_req_if
    import blpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic [RGB_W-1:0]          rgb_color;

    modport source (output valid, req_type, start_x, start_y, end_x, end_y, rgb_color,
                    input ready);
    modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, rgb_color,
                    output ready);
endinterface

interface blpg_pix_if
    import blpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] pixel_x;
    logic signed [FIELD_W-1:0] pixel_y;
    logic [RGB565_W-1:0]       pixel_color;
    logic                      last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface

`default_nettype wire

FILE: src/blpg_colour_conv.sv
// ----------------------------------------------------------------------------
// blpg_colour_conv
// RGB888 to RGB565 with brightness scaling (one 8x8 multiply per channel).
// ----------------------------------------------------------------------------
`default_nettype none

module blpg_colour_conv
    import blpg_pkg::*;
(
    input  wire logic [RGB_W-1:0]    i_rgb,
    input  wire logic [BRIGHT_W-1:0] i_brightness,
    output logic [RGB565_W-1:0]      o_rgb565
);

    logic [15:0] w_r_prod;
    logic [15:0] w_g_prod;
    logic [15:0] w_b_prod;
    logic [RGB565_W-1:0] w_trunc;

    assign w_r_prod = 16'(i_rgb[23:16]) * 16'(i_brightness);
    assign w_g_prod = 16'(i_rgb[15:8])  * 16'(i_brightness);
    assign w_b_prod = 16'(i_rgb[7:0])   * 16'(i_brightness);

    assign w_trunc = RGB565_W'(((i_rgb & RGB_R_MASK) >> 8) | ((i_rgb & RGB_G_MASK) >> 5)
                   | ((i_rgb & RGB_B_MASK) >> 3));

    always_comb begin
        if (i_brightness == BRIGHT_BLACK) begin
            o_rgb565 = '0;
        end else if (i_brightness == BRIGHT_FULL) begin
            o_rgb565 = w_trunc;
        end else begin
            o_rgb565 = (w_r_prod & RGB565_R)
                     | ((w_g_prod >> 5) & RGB565_G)
                     | ((w_b_prod >> 11) & RGB565_B);
        end
    end

endmodule

`default_nettype wire

FILE: src/blpg_line_engine.sv
// ----------------------------------------------------------------------------
// blpg_line_engine
// Line stepping state: set-up on start, one error-accumulator step per advance on an active line.
// ----------------------------------------------------------------------------
`default_nettype none

module blpg_line_engine
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_eng_ctl              i_ctl,
    input  wire logic [COORD_BITS-1:0] i_x0,
    input  wire logic [COORD_BITS-1:0] i_y0,
    input  wire logic [COORD_BITS-1:0] i_x1,
    input  wire logic [COORD_BITS-1:0] i_y1,
    input  wire logic [RGB565_W-1:0]   i_colour,
    output t_eng_sts                   o_sts,
    output t_pixel                     o_pixel
);

    localparam int LEN_W = COORD_BITS + 1;
    localparam int ACC_W = COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic [1:0]            r_diag_x, n_diag_x;
    logic [1:0]            r_diag_y, n_diag_y;
    logic [1:0]            r_str_x, n_str_x;
    logic [1:0]            r_str_y, n_str_y;
    logic [LEN_W-1:0]      r_major, n_major;
    logic [LEN_W-1:0]      r_minor, n_minor;
    logic [ACC_W-1:0]      r_err, n_err;
    logic [LEN_W-1:0]      r_left, n_left;
    logic [RGB565_W-1:0]   r_colour, n_colour;

    logic signed [LEN_W-1:0] w_dx;
    logic signed [LEN_W-1:0] w_dy;
    logic [LEN_W-1:0]        w_adx;
    logic [LEN_W-1:0]        w_ady;
    logic [1:0]              w_sgn_x;
    logic [1:0]              w_sgn_y;
    logic [ACC_W-1:0]        w_acc_sum;
    logic                    w_diag;
    logic [1:0]              w_step_x;
    logic [1:0]              w_step_y;

    // set-up arithmetic on the end points
    assign w_dx  = LEN_W'($signed(i_x1)) - LEN_W'($signed(i_x0));
    assign w_dy  = LEN_W'($signed(i_y1)) - LEN_W'($signed(i_y0));
    assign w_adx = w_dx[LEN_W-1] ? LEN_W'(-w_dx) : LEN_W'(w_dx);
    assign w_ady = w_dy[LEN_W-1] ? LEN_W'(-w_dy) : LEN_W'(w_dy);
    assign w_sgn_x = w_dx[LEN_W-1] ? 2'b11 : {1'b0, (w_dx != '0)};
    assign w_sgn_y = w_dy[LEN_W-1] ? 2'b11 : {1'b0, (w_dy != '0)};

    // advance step
    assign w_acc_sum = r_err + ACC_W'(r_minor);
    assign w_diag    = (w_acc_sum >= ACC_W'(r_major));
    assign w_step_x  = w_diag ? r_diag_x : r_str_x;
    assign w_step_y  = w_diag ? r_diag_y : r_str_y;

    assign o_sts.line_active = (r_left != '0);

    assign o_pixel.pixel_x     = FIELD_W'($signed(r_cur_x));
    assign o_pixel.pixel_y     = FIELD_W'($signed(r_cur_y));
    assign o_pixel.pixel_color = r_colour;
    assign o_pixel.last_pixel  = (r_left == LEN_W'(1));

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_diag_x = r_diag_x;
        n_diag_y = r_diag_y;
        n_str_x  = r_str_x;
        n_str_y  = r_str_y;
        n_major  = r_major;
        n_minor  = r_minor;
        n_err    = r_err;
        n_left   = r_left;
        n_colour = r_colour;
        if (i_ctl.fire && i_ctl.start) begin
            n_cur_x  = i_x0;
            n_cur_y  = i_y0;
            n_diag_x = w_sgn_x;
            n_diag_y = w_sgn_y;
            n_colour = i_colour;
            if (w_adx < w_ady) begin
                n_major = w_ady;
                n_minor = w_adx;
                n_str_x = 2'b00;
                n_str_y = w_sgn_y;
            end else begin
                n_major = w_adx;
                n_minor = w_ady;
                n_str_x = w_sgn_x;
                n_str_y = 2'b00;
            end
            n_err  = ACC_W'(n_major >> 1);
            n_left = n_major;
        end else if (i_ctl.fire && o_sts.line_active) begin
            n_err   = w_diag ? (w_acc_sum - ACC_W'(r_major)) : w_acc_sum;
            n_cur_x = r_cur_x + COORD_BITS'($signed(w_step_x));
            n_cur_y = r_cur_y + COORD_BITS'($signed(w_step_y));
            n_left  = r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_diag_x <= '0;
            r_diag_y <= '0;
            r_str_x  <= '0;
            r_str_y  <= '0;
            r_major  <= '0;
            r_minor  <= '0;
            r_err    <= '0;
            r_left   <= '0;
            r_colour <= '0;
        end else begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_diag_x <= n_diag_x;
            r_diag_y <= n_diag_y;
            r_str_x  <= n_str_x;
            r_str_y  <= n_str_y;
            r_major  <= n_major;
            r_minor  <= n_minor;
            r_err    <= n_err;
            r_left   <= n_left;
            r_colour <= n_colour;
        end
    end

endmodule

`default_nettype wire

FILE: src/bresenham_line_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator_top
// Line rasteriser with RGB565 colour conversion under a brightness register.
// ----------------------------------------------------------------------------
// Takes one request word per clock. A start word loads the end points and
// converts the colour (brightness 0 black, 255 plain truncation, else scaled);
// it gives no pixel. Each advance word while a line is active gives one pixel
// word and takes one major step; a line of major length N gives exactly N
// pixels, the end point excluded, last_pixel marking the final one. Advance
// with no active line is dropped. An accepted word waits in the input
// register; an advance on a live line then loads the engine's current pixel
// into the output register on o_pix as the error update steps. Sustained rate
// is one word per cycle, set by that error update; o_pix stalls hold the
// output register and back-pressure i_req only when a pixel has nowhere to go.
// Coordinates use the low COORD_BITS bits of each field as two's complement
// and wrap at that width; outputs are sign-extended to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_pixel_generator_top_macros.svh"

module bresenham_line_pixel_generator_top
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [BRIGHT_W-1:0] i_cfg_wr_data,
    blpg_req_if.sink                 i_req,
    blpg_pix_if.source               o_pix
);

    // input register
    logic                  r_in_valid;
    logic                  r_in_type;
    logic [COORD_BITS-1:0] r_in_x0;
    logic [COORD_BITS-1:0] r_in_y0;
    logic [COORD_BITS-1:0] r_in_x1;
    logic [COORD_BITS-1:0] r_in_y1;
    logic [RGB_W-1:0]      r_in_rgb;

    // output register
    logic   r_out_valid;
    t_pixel r_out_pix;

    logic [BRIGHT_W-1:0] r_brightness;

    logic                w_is_start;
    logic                w_gives_pixel;
    logic                w_proc;
    logic                w_load_out;
    logic [RGB565_W-1:0] w_rgb565;
    t_eng_ctl            w_ctl;
    t_eng_sts            w_sts;
    t_pixel              w_pix;

    // brightness register, to be written only while idle (the block does not enforce it)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            r_brightness <= i_cfg_wr_data;
        end
    end

    // a start never needs the output slot; an advance does only if a line is live
    assign w_is_start    = (r_in_type == REQ_START);
    assign w_gives_pixel = !w_is_start && w_sts.line_active;
    assign w_proc        = r_in_valid && (!w_gives_pixel || !r_out_valid || o_pix.ready);
    assign w_load_out    = w_proc && w_gives_pixel;

    assign i_req.ready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_type <= i_req.req_type;
            r_in_x0   <= i_req.start_x[COORD_BITS-1:0];
            r_in_y0   <= i_req.start_y[COORD_BITS-1:0];
            r_in_x1   <= i_req.end_x[COORD_BITS-1:0];
            r_in_y1   <= i_req.end_y[COORD_BITS-1:0];
            r_in_rgb  <= i_req.rgb_color;
        end
    end

    blpg_colour_conv u_colour (
        .i_rgb        (r_in_rgb),
        .i_brightness (r_brightness),
        .o_rgb565     (w_rgb565)
    );

    assign w_ctl.fire  = w_proc;
    assign w_ctl.start = w_is_start;

    blpg_line_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_x0     (r_in_x0),
        .i_y0     (r_in_y0),
        .i_x1     (r_in_x1),
        .i_y1     (r_in_y1),
        .i_colour (w_rgb565),
        .o_sts    (w_sts),
        .o_pixel  (w_pix)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_pix <= w_pix;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_pix.pixel_x;
    assign o_pix.pixel_y     = r_out_pix.pixel_y;
    assign o_pix.pixel_color = r_out_pix.pixel_color;
    assign o_pix.last_pixel  = r_out_pix.last_pixel;

    // checks
    `BLPG_ASSERT_NEXT(a_out_hold, r_out_valid && !o_pix.ready, r_out_valid && $stable(r_out_pix), "pixel word lost under stall")
    `BLPG_ASSERT_NOW(a_start_drains, r_in_valid && w_is_start, w_proc, "start word held in input register")
    `BLPG_ASSERT_NOW(a_empty_ready, !r_in_valid, i_req.ready, "empty input register not ready")
    `BLPG_ASSERT_NEXT(a_last_ends_line, w_load_out && w_pix.last_pixel, !w_sts.line_active || $past(w_is_start), "line still active after last pixel")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line pixel generator.
// ----------------------------------------------------------------------------
// Request words go in on a valid/ready channel and pixel words come back on
// another. A behavioural rasteriser inside the bench follows every accepted
// request word and queues the pixel word it should give. Each pixel word taken
// from the block is then checked field by field against the head of that
// queue. A short hand-written table opens the run. Random phases follow, each
// under a brightness and idling pattern set for it, and one of them holds the pixel
// sink off long enough to fill the block and stall its request side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import blpg_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 8;      // pipeline is two deep, leave margin
    localparam int HOLD_CYCLES   = 300;    // long sink hold-off in the pressure phase
    localparam int PHASE_WORDS   = 100;
    localparam int NO_CFG        = -1;
    localparam logic [RGB_W-1:0]    WHITE       = 24'hffffff;
    localparam logic [RGB565_W-1:0] WHITE_565   = 16'hffff;

    // one request word as the bench sees it
    typedef struct packed {
        t_req_type                 kind;
        logic signed [FIELD_W-1:0] sx;
        logic signed [FIELD_W-1:0] sy;
        logic signed [FIELD_W-1:0] ex;
        logic signed [FIELD_W-1:0] ey;
        logic [RGB_W-1:0]          rgb;
    } t_req_word;

    // directed table row; bright is written first (after a settle) unless NO_CFG
    typedef struct {
        t_req_word w;
        int        bright;
        bit        typed;
        bit        has_pix;
        t_pixel    pix;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [BRIGHT_W-1:0] cfg_wr_data;

    blpg_req_if req_if ();
    blpg_pix_if pix_if ();

    bresenham_line_pixel_generator_top #(
        .COORD_BITS (16)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_if),
        .o_pix         (pix_if)
    );

    // ------------------------------------------------------------------------
    // Rasteriser state, mirrored from the block's behaviour
    // ------------------------------------------------------------------------
    logic [BRIGHT_W-1:0]       bright;
    logic signed [FIELD_W-1:0] pos_x, pos_y;
    logic signed [1:0]         diag_dx, diag_dy, str_dx, str_dy;
    logic [16:0]               major_len, minor_len, steps_left;
    logic [17:0]               err_acc;
    logic [RGB565_W-1:0]       line_rgb565;

    t_pixel pix_q[$];           // pixel words still owed by the block
    t_row   dir_rows[$];

    int fail_count = 0;
    int word_count = 0;         // request words that did something
    int cycle_cnt  = 0;
    int send_pct   = 0;         // sender idle chance per cycle, percent
    int stall_pct  = 0;         // sink stall chance per cycle, percent
    int hold_req   = 0;         // set by the stimulus to start a long hold-off
    int hold_left  = 0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    // 24-bit colour to RGB565 under brightness b: black, plain truncation,
    // or each channel multiplied by b and the top bits kept.
    function automatic logic [RGB565_W-1:0] rgb565_scale(logic [RGB_W-1:0] rgb,
                                                         logic [BRIGHT_W-1:0] b);
        logic [15:0] rs, gs, bs;
        rs = 16'(rgb[23:16]) * 16'(b);
        gs = 16'(rgb[15:8]) * 16'(b);
        bs = 16'(rgb[7:0]) * 16'(b);
        if (b == BRIGHT_BLACK)
            return '0;
        if (b == BRIGHT_FULL)
            return {rgb[23:19], rgb[15:10], rgb[7:3]};
        return {rs[15:11], gs[15:10], bs[15:11]};
    endfunction

    function automatic logic signed [1:0] sign2(int v);
        return (v < 0) ? -2'sd1 : ((v > 0) ? 2'sd1 : 2'sd0);
    endfunction

    // Follow one accepted request word; returns 1 with the pixel it gives.
    function automatic bit rasterise(input t_req_word w, output t_pixel px);
        int x0, y0, dw, dh, aw, ah;
        px = '0;
        if (w.kind == REQ_START) begin
            x0 = $signed(w.sx);
            y0 = $signed(w.sy);
            dw = int'($signed(w.ex)) - x0;
            dh = int'($signed(w.ey)) - y0;
            aw = (dw < 0) ? -dw : dw;
            ah = (dh < 0) ? -dh : dh;
            line_rgb565 = rgb565_scale(w.rgb, bright);
            pos_x   = w.sx;
            pos_y   = w.sy;
            diag_dx = sign2(dw);
            diag_dy = sign2(dh);
            if (aw < ah) begin
                major_len = 17'(ah);
                minor_len = 17'(aw);
                str_dx    = 2'sd0;
                str_dy    = diag_dy;
            end else begin
                major_len = 17'(aw);
                minor_len = 17'(ah);
                str_dx    = diag_dx;
                str_dy    = 2'sd0;
            end
            err_acc    = 18'(major_len >> 1);
            steps_left = major_len;
            return 1'b0;
        end
        // advance with no line in progress is dropped
        if (steps_left == 0)
            return 1'b0;
        px.pixel_x     = pos_x;
        px.pixel_y     = pos_y;
        px.pixel_color = line_rgb565;
        px.last_pixel  = (steps_left == 1);
        err_acc = err_acc + minor_len;
        if (err_acc >= major_len) begin
            err_acc = err_acc - major_len;
            pos_x   = pos_x + diag_dx;
            pos_y   = pos_y + diag_dy;
        end else begin
            pos_x   = pos_x + str_dx;
            pos_y   = pos_y + str_dy;
        end
        steps_left = steps_left - 1;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel sink: checks each pixel word and drives ready
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : pix_sink
        t_pixel want;
        if (rst_n && pix_if.valid && pix_if.ready) begin
            if (pix_q.size() == 0) begin
                $error("pixel word with none expected: x %0d y %0d colour %h last %0b",
                       pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_color,
                       pix_if.last_pixel);
                fail_count++;
            end else begin
                want = pix_q.pop_front();
                if (pix_if.pixel_x !== want.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix_if.pixel_x);
                    fail_count++;
                end
                if (pix_if.pixel_y !== want.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix_if.pixel_y);
                    fail_count++;
                end
                if (pix_if.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %h, got %h",
                           want.pixel_color, pix_if.pixel_color);
                    fail_count++;
                end
                if (pix_if.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %0b, got %0b",
                           want.last_pixel, pix_if.last_pixel);
                    fail_count++;
                end
            end
        end
        // long hold-off counted here, otherwise random stalls
        if (hold_left != 0) begin
            pix_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_req != 0) begin
            pix_if.ready <= 1'b0;
            hold_left    <= hold_req;
            hold_req     <= 0;
        end else begin
            pix_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Offer one word, wait for it to be taken, then queue what it should give.
    // A typed row overrides the rasteriser's pixel, which still steps.
    task automatic send_word(input t_req_word w, input bit typed, input bit typed_has,
                             input t_pixel typed_px);
        t_pixel px;
        bit     has;
        while ($urandom_range(0, 99) < send_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= w.kind;
        req_if.start_x   <= w.sx;
        req_if.start_y   <= w.sy;
        req_if.end_x     <= w.ex;
        req_if.end_y     <= w.ey;
        req_if.rgb_color <= w.rgb;
        do
            @(posedge clk);
        while (!req_if.ready);
        has = rasterise(w, px);
        if (typed) begin
            has = typed_has;
            px  = typed_px;
        end
        if (has)
            pix_q.push_back(px);
        if (w.kind == REQ_START || has)
            word_count++;
    endtask

    // Drop valid, wait for every owed pixel word, then let the pipe drain.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (pix_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bright(input logic [BRIGHT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        bright       = v;
    endtask

    function automatic t_req_word rand_word(t_req_type k);
        t_req_word w;
        w.kind = k;
        w.sx   = 16'($urandom);
        w.sy   = 16'($urandom);
        w.ex   = 16'($urandom);
        w.ey   = 16'($urandom);
        w.rgb  = 24'($urandom);
        return w;
    endfunction

    // end point a short way from s, kept inside the 16-bit range
    function automatic logic signed [FIELD_W-1:0] near_end(logic signed [FIELD_W-1:0] s,
                                                           int d);
        int e;
        e = int'(s) + d;
        if (e > 32767 || e < -32768)
            e = int'(s) - d;
        return 16'(e);
    endfunction

    function automatic void add_row(t_req_type k, int sx, int sy, int ex, int ey,
                                    logic [RGB_W-1:0] rgb, int b, bit typed, bit has,
                                    int px, int py, logic [RGB565_W-1:0] pc, bit last);
        t_row r;
        r.w.kind = k;
        r.w.sx   = 16'(sx);
        r.w.sy   = 16'(sy);
        r.w.ex   = 16'(ex);
        r.w.ey   = 16'(ey);
        r.w.rgb  = rgb;
        r.bright = b;
        r.typed  = typed;
        r.has_pix = has;
        r.pix.pixel_x     = 16'(px);
        r.pix.pixel_y     = 16'(py);
        r.pix.pixel_color = pc;
        r.pix.last_pixel  = last;
        dir_rows.push_back(r);
    endfunction

    // Random words until the phase target is met. Mostly short well-formed
    // lines, sometimes cut short or overrun; the rest is long random lines
    // soon abandoned, and stray advances.
    task automatic run_phase(input int target);
        t_req_word w;
        int        dx, dy, len, n, roll;
        while (word_count < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                send_word(rand_word(REQ_START), 1'b0, 1'b0, '0);
                repeat ($urandom_range(0, 3))
                    send_word(rand_word(REQ_ADVANCE), 1'b0, 1'b0, '0);
            end else if (roll < 20) begin
                send_word(rand_word(REQ_ADVANCE), 1'b0, 1'b0, '0);
            end else begin
                w    = rand_word(REQ_START);
                w.ex = near_end(w.sx, int'($urandom_range(0, 24)) - 12);
                w.ey = near_end(w.sy, int'($urandom_range(0, 24)) - 12);
                dx   = int'(w.ex) - int'(w.sx);
                dy   = int'(w.ey) - int'(w.sy);
                dx   = (dx < 0) ? -dx : dx;
                dy   = (dy < 0) ? -dy : dy;
                len  = (dx > dy) ? dx : dy;
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(0, len);
                else
                    n = len + $urandom_range(0, 2);
                send_word(w, 1'b0, 1'b0, '0);
                repeat (n)
                    send_word(rand_word(REQ_ADVANCE), 1'b0, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_row r;
        int   target;
        int   p;
        int   ph_send[6]  = '{0, 0, 48, 0, 16, 0};
        int   ph_stall[6] = '{0, 0, 0, 48, 16, 0};
        int   ph_bright[6] = '{255, 0, 1, 128, -1, 254};

        // every input known from time zero
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        req_if.valid     = 1'b0;
        req_if.req_type  = REQ_START;
        req_if.start_x   = '0;
        req_if.start_y   = '0;
        req_if.end_x     = '0;
        req_if.end_y     = '0;
        req_if.rgb_color = '0;
        pix_if.ready     = 1'b0;

        // rasteriser reset state
        bright      = BRIGHT_RESET;
        pos_x       = '0;
        pos_y       = '0;
        diag_dx     = '0;
        diag_dy     = '0;
        str_dx      = '0;
        str_dy      = '0;
        major_len   = '0;
        minor_len   = '0;
        err_acc     = '0;
        steps_left  = '0;
        line_rgb565 = '0;

        // Directed table. Typed rows carry the pixel word read straight off
        // the behaviour; the others go through the rasteriser.
        // advance straight after reset: nothing active, nothing out
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 0, 0, 0, '0, 0);
        // zero-length line gives nothing
        add_row(REQ_START, 0, 0, 0, 0, WHITE, NO_CFG, 1, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 0, 0, 0, '0, 0);
        // three-pixel horizontal line, full brightness, end point left out
        add_row(REQ_START, 0, 0, 3, 0, WHITE, NO_CFG, 1, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 1, 0, 0, WHITE_565, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 1, 1, 0, WHITE_565, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 1, 2, 0, WHITE_565, 1);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 0, 0, 0, '0, 0);
        // corner to corner diagonal, black, abandoned after two pixels
        add_row(REQ_START, -32768, -32768, 32767, 32767, '0, NO_CFG, 1, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 1, -32768, -32768, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 1, 1, -32767, -32767, '0, 0);
        // steep line at the opposite corner replaces it
        add_row(REQ_START, 32767, -32768, 32765, -32763, 24'hf8fcf8, NO_CFG, 0, 0,
                0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        // brightness goes to zero mid-line: latched colour must hold
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, BRIGHT_BLACK, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        // new line at brightness zero, black
        add_row(REQ_START, 100, -100, 90, -97, WHITE, NO_CFG, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        // smallest scaling brightness
        add_row(REQ_START, -5, 7, 2, 7, WHITE, 1, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);
        // mid brightness, diagonal going negative in both axes
        add_row(REQ_START, 0, 0, -4, -4, 24'h123456, 128, 0, 0, 0, 0, '0, 0);
        add_row(REQ_ADVANCE, 0, 0, 0, 0, '0, NO_CFG, 0, 0, 0, 0, '0, 0);

        // synchronous reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            if (r.bright != NO_CFG) begin
                settle();
                write_bright(BRIGHT_W'(r.bright));
            end
            send_word(r.w, r.typed, r.has_pix, r.pix);
        end

        // Random phases: idling pattern and brightness change between them,
        // always with the block drained. Phase 1 also holds the sink off.
        for (p = 0; p < 6; p++) begin
            settle();
            send_pct  = ph_send[p];
            stall_pct = ph_stall[p];
            if (ph_bright[p] < 0)
                write_bright(BRIGHT_W'($urandom_range(2, 253)));
            else
                write_bright(BRIGHT_W'(ph_bright[p]));
            if (p == 1)
                hold_req <= HOLD_CYCLES;
            target = word_count + PHASE_WORDS;
            run_phase(target);
        end

        settle();
        if (fail_count == 0 && pix_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (pix_q.size() != 0)
                $error("%0d pixel words never arrived", pix_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: bresenham_line_pixel_generator_top.f
+incdir+src
src/blpg_pkg.sv
src/blpg_if.sv
src/blpg_colour_conv.sv
src/blpg_line_engine.sv
src/bresenham_line_pixel_generator_top.sv
tb/tb_top.sv
